>>> rtl/spvm_pkg.sv
// ----------------------------------------------------------------------------
// spvm_pkg
// Shared types, constants and helpers for the shower pair vertex/mass block.
// ----------------------------------------------------------------------------
`default_nettype none

package spvm_pkg;

    localparam int DEF_MAX_SHOWERS   = 64;
    localparam int DEF_POS_FRAC_BITS = 6;

    localparam int REG_W   = 17;
    localparam int IDX_W   = 2;
    localparam int POS_W   = 18;
    localparam int DIR_W   = 16;
    localparam int EN_W    = 20;
    localparam int MASS_W  = 20;
    localparam int DIST_W  = 18;
    localparam int SLOT_OUT_W = 6;

    localparam logic signed [31:0] PHOTON_CODE = 32'sd22;

    localparam logic [IDX_W-1:0] REG_BOX_X_MAX  = 2'd0;
    localparam logic [IDX_W-1:0] REG_BOX_Y_HALF = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOX_Z_MAX  = 2'd2;

    localparam int BOX_X_CM  = 256;
    localparam int BOX_Y_CM  = 115;
    localparam int BOX_Z_CM  = 1036;

    localparam logic [MASS_W-1:0] MASS_MAX = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [EN_W-1:0]         energy;
        logic                    contained;
    } t_shower;

    // num_raw is plane minus start; lprod is length times |dir|
    function automatic logic face_crossed(
        input logic signed [POS_W:0] num_raw,
        input logic                  dneg,
        input logic                  dzero,
        input logic [32:0]           lprod
    );
        logic signed [POS_W:0] num;
        num = dneg ? -num_raw : num_raw;
        return !dzero && (num > 0) && ({num[POS_W-1:0], 15'd0} < lprod);
    endfunction

endpackage

`default_nettype wire

>>> rtl/spvm_ram.sv
// ----------------------------------------------------------------------------
// spvm_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

`default_nettype wire

>>> rtl/spvm_queue.sv
// ----------------------------------------------------------------------------
// spvm_queue
// Two-entry queue between the classifying front and the pairing back.
// ----------------------------------------------------------------------------
`default_nettype none

module spvm_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

`default_nettype wire

>>> rtl/spvm_front.sv
// ----------------------------------------------------------------------------
// spvm_front
// Box registers, event photon count, photon selection and box containment.
// ----------------------------------------------------------------------------
`default_nettype none

module spvm_front #(
    parameter int MAX_SHOWERS   = spvm_pkg::DEF_MAX_SHOWERS,
    parameter int POS_FRAC_BITS = spvm_pkg::DEF_POS_FRAC_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_cfg_valid,
    input  wire logic [spvm_pkg::IDX_W-1:0]              i_cfg_index,
    input  wire logic [spvm_pkg::REG_W-1:0]              i_cfg_data,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_stall,
    input  wire logic                                    i_first_of_event,
    input  wire logic signed [31:0]                      i_pdg_code,
    input  wire spvm_pkg::t_shower                       i_shower,
    input  wire logic [spvm_pkg::REG_W-1:0]              i_shower_length,
    output logic                                         o_push,
    output logic [$clog2(MAX_SHOWERS)-1:0]               o_slot,
    output spvm_pkg::t_shower                            o_shower,
    input  wire logic                                    i_full
);
    import spvm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SHOWERS);
    localparam int CNT_W  = $clog2(MAX_SHOWERS + 1);
    localparam logic [REG_W-1:0] RST_X = REG_W'(BOX_X_CM << POS_FRAC_BITS);
    localparam logic [REG_W-1:0] RST_Y = REG_W'(BOX_Y_CM << POS_FRAC_BITS);
    localparam logic [REG_W-1:0] RST_Z = REG_W'(BOX_Z_CM << POS_FRAC_BITS);

    logic [REG_W-1:0]  r_box_x, r_box_y, r_box_z;
    logic [CNT_W-1:0]  r_count, n_base;
    logic              r_hold;
    logic [SLOT_W-1:0] r_slot;
    t_shower           r_item;
    logic [REG_W-1:0]  r_len;
    logic              accept, keep;
    logic [16:0]       ax, ay, az;
    logic [32:0]       px, py, pz;
    logic signed [POS_W:0] sx, sy, sz;
    logic              crossed;

    assign o_in_stall = r_hold && i_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_base     = i_first_of_event ? '0 : r_count;
    assign keep       = (i_pdg_code == PHOTON_CODE) && (n_base < CNT_W'(MAX_SHOWERS));
    assign o_push     = r_hold && !i_full;
    assign o_slot     = r_slot;

    assign ax = r_item.dir_x[DIR_W-1] ? 17'(-r_item.dir_x) : 17'(r_item.dir_x);
    assign ay = r_item.dir_y[DIR_W-1] ? 17'(-r_item.dir_y) : 17'(r_item.dir_y);
    assign az = r_item.dir_z[DIR_W-1] ? 17'(-r_item.dir_z) : 17'(r_item.dir_z);
    assign px = 33'(r_len * ax);
    assign py = 33'(r_len * ay);
    assign pz = 33'(r_len * az);
    assign sx = (POS_W+1)'(r_item.start_x);
    assign sy = (POS_W+1)'(r_item.start_y);
    assign sz = (POS_W+1)'(r_item.start_z);

    always_comb begin
        crossed =
            face_crossed($signed({2'b00, r_box_z}) - sz, r_item.dir_z[DIR_W-1],
                         r_item.dir_z == '0, pz) ||
            face_crossed(-sz, r_item.dir_z[DIR_W-1], r_item.dir_z == '0, pz) ||
            face_crossed($signed({2'b00, r_box_y}) - sy, r_item.dir_y[DIR_W-1],
                         r_item.dir_y == '0, py) ||
            face_crossed(-$signed({2'b00, r_box_y}) - sy, r_item.dir_y[DIR_W-1],
                         r_item.dir_y == '0, py) ||
            face_crossed($signed({2'b00, r_box_x}) - sx, r_item.dir_x[DIR_W-1],
                         r_item.dir_x == '0, px) ||
            face_crossed(-sx, r_item.dir_x[DIR_W-1], r_item.dir_x == '0, px);
        o_shower           = r_item;
        o_shower.contained = !crossed;
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_item <= i_shower;
            r_len  <= i_shower_length;
            r_slot <= SLOT_W'(n_base);
        end
        if (!i_rst_n) begin
            r_box_x <= RST_X;
            r_box_y <= RST_Y;
            r_box_z <= RST_Z;
            r_count <= '0;
            r_hold  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_BOX_X_MAX:  r_box_x <= i_cfg_data;
                    REG_BOX_Y_HALF: r_box_y <= i_cfg_data;
                    REG_BOX_Z_MAX:  r_box_z <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_count <= keep ? n_base + 1'b1 : n_base;
                r_hold  <= keep;
            end else if (o_push) begin
                r_hold <= 1'b0;
            end
        end
    end
endmodule

`default_nettype wire

>>> rtl/spvm_back.sv
// ----------------------------------------------------------------------------
// spvm_back
// Pairs each queued photon with the stored ones: shared multiplier, square
// root and divider sequenced per pair, then appends the photon to the store.
// ----------------------------------------------------------------------------
`default_nettype none

module spvm_back #(
    parameter int MAX_SHOWERS = spvm_pkg::DEF_MAX_SHOWERS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire logic [$clog2(MAX_SHOWERS)-1:0] i_q_slot,
    input  wire spvm_pkg::t_shower             i_q_shower,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [spvm_pkg::MASS_W-1:0]        o_pair_mass,
    output logic [spvm_pkg::DIST_W-1:0]        o_approach_distance,
    output logic [1:0]                         o_contained_count,
    output logic                               o_parallel_pair,
    output logic [spvm_pkg::SLOT_OUT_W-1:0]    o_partner_slot,
    output logic                               o_last_pair
);
    import spvm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SHOWERS);
    localparam int ITEM_W = $bits(t_shower);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SQN   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_SQM   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;
    localparam logic [2:0] S_WRITE = 3'd7;

    localparam logic [4:0]  LAST_STEP = 5'd17;
    localparam logic [5:0]  SQ_ITERS  = 6'd31;
    localparam logic [5:0]  DIV_ITERS = 6'd54;
    localparam logic [63:0] SQ_TOP    = 64'h4000_0000_0000_0000;

    logic [2:0]         r_state;
    t_shower            r_cur;
    logic [SLOT_W-1:0]  r_slot, r_k;
    logic [4:0]         r_step;
    logic [5:0]         r_cnt;
    logic signed [33:0] r_cos, r_nx, r_ny, r_nz;
    logic [63:0]        r_nn;
    logic signed [53:0] r_dot;
    logic [39:0]        r_p;
    logic [52:0]        r_hi;
    logic [43:0]        r_m2;
    logic [63:0]        r_sq_v, r_sq_r, r_sq_bit;
    logic [32:0]        r_rem;
    logic [54:0]        r_dvd, r_quo;
    logic [31:0]        r_nmag;
    logic               r_par;
    logic [DIST_W-1:0]  r_dist;
    logic [MASS_W-1:0]  r_mass;

    logic [ITEM_W-1:0]  rd_raw;
    t_shower            rd;
    logic               ram_rd, ram_wr;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic signed [34:0] qs;
    logic [32:0]        q;
    logic [72:0]        pq;
    logic [63:0]        sq_sum, sq_r_next;
    logic               sq_ge;
    logic [32:0]        rem_sh;
    logic               div_ge;
    logic [54:0]        quo_next;
    logic [53:0]        dot_abs;
    logic signed [POS_W:0] wx, wy, wz;
    logic               out_free;

    assign rd = t_shower'(rd_raw);
    assign ram_rd = (r_state == S_READ);
    assign ram_wr = (r_state == S_WRITE);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !o_out_valid || !i_out_stall;

    spvm_ram #(
        .WIDTH (ITEM_W),
        .DEPTH (MAX_SHOWERS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr),
        .i_wr_addr (r_slot),
        .i_wr_data (r_cur),
        .i_rd_en   (ram_rd),
        .i_rd_addr (r_k),
        .o_rd_data (rd_raw)
    );

    assign wx = (POS_W+1)'(r_cur.start_x) - (POS_W+1)'(rd.start_x);
    assign wy = (POS_W+1)'(r_cur.start_y) - (POS_W+1)'(rd.start_y);
    assign wz = (POS_W+1)'(r_cur.start_z) - (POS_W+1)'(rd.start_z);

    assign qs = (35'sd1 <<< 30) - 35'(r_cos);
    assign q  = qs[34] ? '0 : qs[32:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            5'd0:  begin mul_a = 34'(r_cur.dir_x); mul_b = 34'(rd.dir_x); end
            5'd1:  begin mul_a = 34'(r_cur.dir_y); mul_b = 34'(rd.dir_y); end
            5'd2:  begin mul_a = 34'(r_cur.dir_z); mul_b = 34'(rd.dir_z); end
            5'd3:  begin mul_a = 34'(r_cur.dir_y); mul_b = 34'(rd.dir_z); end
            5'd4:  begin mul_a = 34'(r_cur.dir_z); mul_b = 34'(rd.dir_y); end
            5'd5:  begin mul_a = 34'(r_cur.dir_z); mul_b = 34'(rd.dir_x); end
            5'd6:  begin mul_a = 34'(r_cur.dir_x); mul_b = 34'(rd.dir_z); end
            5'd7:  begin mul_a = 34'(r_cur.dir_x); mul_b = 34'(rd.dir_y); end
            5'd8:  begin mul_a = 34'(r_cur.dir_y); mul_b = 34'(rd.dir_x); end
            5'd9:  begin mul_a = r_nx; mul_b = r_nx; end
            5'd10: begin mul_a = r_ny; mul_b = r_ny; end
            5'd11: begin mul_a = r_nz; mul_b = r_nz; end
            5'd12: begin mul_a = 34'(wx); mul_b = r_nx; end
            5'd13: begin mul_a = 34'(wy); mul_b = r_ny; end
            5'd14: begin mul_a = 34'(wz); mul_b = r_nz; end
            5'd15: begin
                mul_a = $signed({14'd0, r_cur.energy});
                mul_b = $signed({14'd0, rd.energy});
            end
            5'd16: begin
                mul_a = $signed({14'd0, r_p[39:20]});
                mul_b = $signed({1'b0, q});
            end
            5'd17: begin
                mul_a = $signed({14'd0, r_p[19:0]});
                mul_b = $signed({1'b0, q});
            end
            default: ;
        endcase
    end

    assign prod = mul_a * mul_b;
    assign pq   = {r_hi, 20'd0} + 73'(prod[52:0]);

    assign sq_sum    = r_sq_r + r_sq_bit;
    assign sq_ge     = (r_sq_v >= sq_sum);
    assign sq_r_next = sq_ge ? (r_sq_r >> 1) + r_sq_bit : (r_sq_r >> 1);

    assign rem_sh   = {r_rem[31:0], r_dvd[54]};
    assign div_ge   = (rem_sh >= {1'b0, r_nmag});
    assign quo_next = {r_quo[53:0], div_ge};
    assign dot_abs  = r_dot[53] ? 54'(-r_dot) : 54'(r_dot);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MUL: begin
                case (r_step)
                    5'd0:  r_cos <= prod[33:0];
                    5'd1,
                    5'd2:  r_cos <= r_cos + prod[33:0];
                    5'd3:  r_nx  <= prod[33:0];
                    5'd4:  r_nx  <= r_nx - prod[33:0];
                    5'd5:  r_ny  <= prod[33:0];
                    5'd6:  r_ny  <= r_ny - prod[33:0];
                    5'd7:  r_nz  <= prod[33:0];
                    5'd8:  r_nz  <= r_nz - prod[33:0];
                    5'd9:  r_nn  <= prod[63:0];
                    5'd10,
                    5'd11: r_nn  <= r_nn + prod[63:0];
                    5'd12: r_dot <= prod[53:0];
                    5'd13,
                    5'd14: r_dot <= r_dot + prod[53:0];
                    5'd15: r_p   <= prod[39:0];
                    5'd16: r_hi  <= prod[52:0];
                    default: begin
                        r_m2     <= pq[72:29];
                        r_sq_v   <= r_nn;
                        r_sq_r   <= '0;
                        r_sq_bit <= SQ_TOP;
                    end
                endcase
            end
            S_SQN, S_SQM: begin
                if (sq_ge) begin
                    r_sq_v <= r_sq_v - sq_sum;
                end
                r_sq_r   <= sq_r_next;
                r_sq_bit <= r_sq_bit >> 2;
                if (r_cnt == '0) begin
                    if (r_state == S_SQN) begin
                        r_nmag <= sq_r_next[31:0];
                        r_par  <= (r_nn == '0);
                        r_dist <= DIST_MAX;
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dvd  <= 55'(dot_abs) + 55'(sq_r_next[31:1]);
                        if (r_nn == '0) begin
                            r_sq_v   <= 64'(r_m2);
                            r_sq_r   <= '0;
                            r_sq_bit <= SQ_TOP;
                        end
                    end else begin
                        r_mass <= (sq_r_next > 64'(MASS_MAX)) ? MASS_MAX
                                                              : sq_r_next[MASS_W-1:0];
                    end
                end
            end
            S_DIV: begin
                r_rem <= div_ge ? rem_sh - {1'b0, r_nmag} : rem_sh;
                r_dvd <= r_dvd << 1;
                r_quo <= quo_next;
                if (r_cnt == '0) begin
                    r_dist   <= (quo_next > 55'(DIST_MAX)) ? DIST_MAX
                                                           : quo_next[DIST_W-1:0];
                    r_sq_v   <= 64'(r_m2);
                    r_sq_r   <= '0;
                    r_sq_bit <= SQ_TOP;
                end
            end
            default: ;
        endcase

        if (o_q_pop) begin
            r_cur  <= i_q_shower;
            r_slot <= i_q_slot;
        end

        if (r_state == S_EMIT && out_free) begin
            o_pair_mass         <= r_mass;
            o_approach_distance <= r_dist;
            o_contained_count   <= 2'(r_cur.contained) + 2'(rd.contained);
            o_parallel_pair     <= r_par;
            o_partner_slot      <= SLOT_OUT_W'(r_k);
            o_last_pair         <= (r_k + 1'b1 == r_slot);
        end

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_step      <= '0;
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_k     <= '0;
                        r_state <= (i_q_slot == '0) ? S_WRITE : S_READ;
                    end
                end
                S_READ: begin
                    r_step  <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_cnt   <= SQ_ITERS;
                        r_state <= S_SQN;
                    end
                end
                S_SQN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_cnt   <= (r_nn == '0) ? SQ_ITERS : DIV_ITERS;
                        r_state <= (r_nn == '0) ? S_SQM : S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_cnt   <= SQ_ITERS;
                        r_state <= S_SQM;
                    end
                end
                S_SQM: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        if (r_k + 1'b1 == r_slot) begin
                            r_state <= S_WRITE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_nmag != '0))
        else $error("divide by zero in approach distance");

    a_partner_below_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_k < r_slot))
        else $error("partner index beyond photon store");

    a_parallel_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_parallel_pair) |-> (o_approach_distance == DIST_MAX))
        else $error("parallel pair without saturated distance");
`endif
endmodule

`default_nettype wire

>>> rtl/shower_pair_vertex_mass.sv
// ----------------------------------------------------------------------------
// shower_pair_vertex_mass - diphoton closest approach and invariant mass
// Each pair runs read, 18 shared-multiplier steps, a square root, a divide,
// a second square root and emit; a parallel pair skips the divide. The back
// takes the next queued photon only after all its pairs and the store write;
// output stalls hold it in emit. Synchronous active-low reset clears
// control only.
// ----------------------------------------------------------------------------
`default_nettype none

module shower_pair_vertex_mass #(
    parameter int MAX_SHOWERS   = spvm_pkg::DEF_MAX_SHOWERS,
    parameter int POS_FRAC_BITS = spvm_pkg::DEF_POS_FRAC_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [spvm_pkg::IDX_W-1:0]         i_cfg_index,
    input  wire logic [spvm_pkg::REG_W-1:0]         i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_first_of_event,
    input  wire logic signed [31:0]                 i_pdg_code,
    input  wire logic signed [spvm_pkg::POS_W-1:0]  i_start_x,
    input  wire logic signed [spvm_pkg::POS_W-1:0]  i_start_y,
    input  wire logic signed [spvm_pkg::POS_W-1:0]  i_start_z,
    input  wire logic signed [spvm_pkg::DIR_W-1:0]  i_dir_x,
    input  wire logic signed [spvm_pkg::DIR_W-1:0]  i_dir_y,
    input  wire logic signed [spvm_pkg::DIR_W-1:0]  i_dir_z,
    input  wire logic [spvm_pkg::EN_W-1:0]          i_energy,
    input  wire logic [spvm_pkg::REG_W-1:0]         i_shower_length,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [spvm_pkg::MASS_W-1:0]             o_pair_mass,
    output logic [spvm_pkg::DIST_W-1:0]             o_approach_distance,
    output logic [1:0]                              o_contained_count,
    output logic                                    o_parallel_pair,
    output logic [spvm_pkg::SLOT_OUT_W-1:0]         o_partner_slot,
    output logic                                    o_last_pair
);
    import spvm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_SHOWERS);
    localparam int Q_W    = SLOT_W + $bits(t_shower);

    t_shower           in_shower, f_shower, q_shower;
    logic              f_push, q_full, q_valid, q_pop;
    logic [SLOT_W-1:0] f_slot, q_slot;
    logic [Q_W-1:0]    q_data;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_shower.start_x   = i_start_x;
        in_shower.start_y   = i_start_y;
        in_shower.start_z   = i_start_z;
        in_shower.dir_x     = i_dir_x;
        in_shower.dir_y     = i_dir_y;
        in_shower.dir_z     = i_dir_z;
        in_shower.energy    = i_energy;
        in_shower.contained = 1'b0;
    end

    spvm_front #(
        .MAX_SHOWERS   (MAX_SHOWERS),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_first_of_event (i_first_of_event),
        .i_pdg_code       (i_pdg_code),
        .i_shower         (in_shower),
        .i_shower_length  (i_shower_length),
        .o_push           (f_push),
        .o_slot           (f_slot),
        .o_shower         (f_shower),
        .i_full           (q_full)
    );

    spvm_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_slot, f_shower}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_slot   = q_data[Q_W-1 -: SLOT_W];
    assign q_shower = t_shower'(q_data[$bits(t_shower)-1:0]);

    spvm_back #(
        .MAX_SHOWERS (MAX_SHOWERS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_q_slot            (q_slot),
        .i_q_shower          (q_shower),
        .o_q_pop             (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_pair_mass         (o_pair_mass),
        .o_approach_distance (o_approach_distance),
        .o_contained_count   (o_contained_count),
        .o_parallel_pair     (o_parallel_pair),
        .o_partner_slot      (o_partner_slot),
        .o_last_pair         (o_last_pair)
    );
endmodule

`default_nettype wire
